### src/sdcd_pkg.sv
`timescale 1ns / 1ps

package sdcd_pkg;

  localparam int unsigned DivWidth = 32;
  localparam int unsigned VerWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [DivWidth-1:0] BaseClockReset = 32'd41666666;
  localparam logic [VerWidth-1:0] HostVersionReset = 8'd0;
  // spec versions above this one use the 10-bit divided clock
  localparam logic [VerWidth-1:0] TenBitMinVersion = 8'd1;
  localparam logic [DivWidth-1:0] MinDivisor = 32'd2;

  localparam logic [CfgIdxWidth-1:0] CfgBaseClock = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgHostVersion = 2'd1;

  // partial state of one restoring division request
  typedef struct packed {
    logic [DivWidth-1:0] rem;
    logic [DivWidth-1:0] den;
    logic [DivWidth-1:0] quo;
  } div_state_t;

endpackage

### src/sdcd_div_cell.sv
`timescale 1ns / 1ps

module sdcd_div_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  sdcd_pkg::div_state_t    data_i,
  input  logic                    num_bit_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output sdcd_pkg::div_state_t    data_o
);

  logic                 valid_q;
  sdcd_pkg::div_state_t data_q;
  sdcd_pkg::div_state_t data_d;
  logic [sdcd_pkg::DivWidth:0] rem_sh;
  logic [sdcd_pkg::DivWidth:0] den_ext;
  logic [sdcd_pkg::DivWidth:0] diff;
  logic                        ge;

  assign ready_o = !valid_q || ready_i;

  // shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    rem_sh = {data_i.rem, num_bit_i};
    den_ext = {1'b0, data_i.den};
    diff = rem_sh - den_ext;
    ge = (rem_sh >= den_ext);
    data_d.den = data_i.den;
    data_d.rem = ge ? diff[sdcd_pkg::DivWidth-1:0] : rem_sh[sdcd_pkg::DivWidth-1:0];
    data_d.quo = {data_i.quo[sdcd_pkg::DivWidth-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.den != '0) |-> data_q.rem < data_q.den)
    else $error("remainder not below divisor");

endmodule

### src/sdcd_select.sv
`timescale 1ns / 1ps

module sdcd_select (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [sdcd_pkg::DivWidth-1:0]  quo_i,
  input  logic [sdcd_pkg::VerWidth-1:0]  host_version_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [15:0]                    clock_field_o,
  output logic [sdcd_pkg::DivWidth-1:0]  divisor_o
);

  logic                          valid_q;
  logic [15:0]                   field_q;
  logic [15:0]                   field_d;
  logic [sdcd_pkg::DivWidth-1:0] divisor_q;
  logic [sdcd_pkg::DivWidth-1:0] divisor_d;
  logic [sdcd_pkg::DivWidth-1:0] x;
  logic [sdcd_pkg::DivWidth-1:0] d_raw;
  logic [2:0]                    shift;
  logic                          ten_bit;

  assign ten_bit = host_version_i > sdcd_pkg::TenBitMinVersion;
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    x = quo_i - sdcd_pkg::DivWidth'(1);
    shift = 3'd0;
    if (|x[sdcd_pkg::DivWidth-1:7]) begin
      shift = 3'd7;
    end else begin
      for (int i = 1; i < 7; i++) begin
        if (x[i]) shift = 3'(i);
      end
    end
    d_raw = ten_bit ? quo_i : (sdcd_pkg::DivWidth'(1) << shift);
    divisor_d = (d_raw <= sdcd_pkg::MinDivisor) ? sdcd_pkg::MinDivisor : d_raw;
    field_d = {divisor_d[7:0], (ten_bit ? divisor_d[9:8] : 2'b00), 6'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      field_q <= field_d;
      divisor_q <= divisor_d;
    end
  end

  assign valid_o = valid_q;
  assign clock_field_o = field_q;
  assign divisor_o = divisor_q;

  a_divisor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> divisor_q >= sdcd_pkg::MinDivisor)
    else $error("divisor below minimum");

  a_pow2_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ten_bit |-> $onehot(divisor_q) && divisor_q[sdcd_pkg::DivWidth-1:8] == '0)
    else $error("power-of-two divisor out of range");

  a_field_packing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> field_q[5:0] == 6'b0 && field_q[15:8] == divisor_q[7:0])
    else $error("clock field packing mismatch");

endmodule

### src/sd_clock_divisor_calc.sv
`timescale 1ns / 1ps
// Pipeline: a request passes through 32 division cells, one quotient bit each, and then the
// divisor select register before its result reaches the master side.
// Throughput: one request per cycle; each cell and the output register stall only when full
// and the stage after it does not take its data.
// Reset: asynchronous, active low; empties the pipeline, base clock 41666666, host version 0.

module sd_clock_divisor_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] target_freq_hz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] clock_field, [47:16] divisor
);

  localparam int unsigned N = sdcd_pkg::DivWidth;

  logic [N-1:0]                  base_q;
  logic [sdcd_pkg::VerWidth-1:0] version_q;

  logic                 valid_c [0:N];
  logic                 ready_c [0:N];
  sdcd_pkg::div_state_t data_c  [0:N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= sdcd_pkg::BaseClockReset;
      version_q <= sdcd_pkg::HostVersionReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sdcd_pkg::CfgBaseClock: base_q <= cfg_wdata_i;
        sdcd_pkg::CfgHostVersion: version_q <= cfg_wdata_i[sdcd_pkg::VerWidth-1:0];
        default: ;
      endcase
    end
  end

  // a zero target keeps every step subtracting, so the quotient saturates to all ones
  assign valid_c[0] = s_axis_tvalid;
  assign s_axis_tready = ready_c[0];
  assign data_c[0].rem = '0;
  assign data_c[0].den = s_axis_tdata;
  assign data_c[0].quo = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    sdcd_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid_c[k]),
      .ready_o   (ready_c[k]),
      .data_i    (data_c[k]),
      .num_bit_i (base_q[N-1-k]),
      .valid_o   (valid_c[k+1]),
      .ready_i   (ready_c[k+1]),
      .data_o    (data_c[k+1])
    );
  end

  sdcd_select u_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_c[N]),
    .ready_o        (ready_c[N]),
    .quo_i          (data_c[N].quo),
    .host_version_i (version_q),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .clock_field_o  (m_axis_tdata[15:0]),
    .divisor_o      (m_axis_tdata[47:16])
  );

endmodule
